### rtl/core/nfp_pkg.sv
// Package for the NAL unit fragment planner: payload structs, codes,
// state enums and shared constants. No dependencies.
package nfp_pkg;

  // Field widths fixed by the item format
  localparam int unsigned FieldW   = 20;
  localparam int unsigned TypeW    = 6;
  localparam int unsigned MaxPayW  = 16;
  localparam int unsigned HdrW     = 2;
  localparam int unsigned FuW      = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // Defaults for the top-level parameter and the size mask
  localparam int unsigned MaxFragmentsDef = 64;
  localparam int unsigned SizeBits        = 20;
  localparam logic [FieldW-1:0] SizeMask =
    (SizeBits >= FieldW) ? {FieldW{1'b1}} : FieldW'((64'd1 << SizeBits) - 64'd1);

  // Divider widths: numerator holds data plus divisor minus one
  localparam int unsigned DivNumW = FieldW + 1;
  localparam int unsigned DivDenW = MaxPayW;

  // Job queue depth
  localparam int unsigned QDepth = 2;

  // Register reset values and register indexes
  localparam logic [MaxPayW-1:0] MaxPayloadRst = 16'd1200;
  localparam logic [HdrW-1:0]    HdrBytesRst   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgHdrBytes   = 4'd1;

  // FU header bits
  localparam logic [FuW-1:0] FuStart  = 8'b1000_0000;
  localparam logic [FuW-1:0] FuEnd    = 8'b0100_0000;
  localparam logic [FuW-1:0] TypeMask = 8'b0011_1111;

  typedef enum logic [1:0] {
    StPacket    = 2'd0,
    StBadHeader = 2'd1,
    StTooMany   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JobBad,
    JobTooMany,
    JobSingle,
    JobFrag
  } job_kind_e;

  typedef enum logic [2:0] {
    FIdle,
    FCntStart,
    FCntWait,
    FSplStart,
    FSplWait,
    FPush
  } front_state_e;

  typedef enum logic {
    BIdle,
    BEmit
  } back_state_e;

  typedef struct packed {
    logic [FieldW-1:0] nal_size;
    logic [TypeW-1:0]  nal_type;
    logic              header_valid;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic              fragmented;
    logic [FuW-1:0]    fu_header;
    logic [FieldW-1:0] chunk_offset;
    logic [FieldW-1:0] copy_bytes;
    logic [FieldW-1:0] payload_size;
    logic              marker;
    logic              last_result;
  } out_item_t;

  // Classified unit handed from front to back; amount is the unit size
  // for a single packet or the base chunk size for fragments
  typedef struct packed {
    job_kind_e         kind;
    logic [TypeW-1:0]  nal_type;
    logic              frame_end;
    logic [HdrW-1:0]   hdr_bytes;
    logic [FieldW-1:0] amount;
  } job_t;

endpackage

### rtl/core/nfp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nfp_pkg for operand widths.
module nfp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [nfp_pkg::DivNumW-1:0] num_i,
  input  logic [nfp_pkg::DivDenW-1:0] den_i,
  output logic                        done_o,
  output logic [nfp_pkg::DivNumW-1:0] quo_o,
  output logic [nfp_pkg::DivDenW-1:0] rem_o
);

  localparam int unsigned NumW  = nfp_pkg::DivNumW;
  localparam int unsigned DenW  = nfp_pkg::DivDenW;
  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [StepW-1:0] step_q;
  logic             done_q;
  logic [DenW-1:0]  acc_q;
  logic [NumW-1:0]  nq_q;
  logic [DenW-1:0]  den_q;

  logic [DenW:0] shifted;
  logic [DenW:0] diff;
  logic          ge;

  // One trial subtraction per step
  assign shifted = {acc_q, nq_q[NumW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= StepW'(NumW);
      end else if (step_q != '0) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      nq_q  <= num_i;
      den_q <= den_i;
    end else if (step_q != '0) begin
      acc_q <= ge ? diff[DenW-1:0] : shifted[DenW-1:0];
      nq_q  <= {nq_q[NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;
  assign rem_o  = acc_q;

endmodule

### rtl/core/nfp_front.sv
// Front end: accepts a NAL unit, classifies it and works out the fragment
// count and base chunk size with the shared divider. Depends on nfp_pkg.
module nfp_front #(
  parameter int unsigned MaxFragments = nfp_pkg::MaxFragmentsDef,
  parameter int unsigned CntW         = $clog2(MaxFragments + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  nfp_pkg::in_item_t           in_data_i,
  input  logic [nfp_pkg::MaxPayW-1:0] max_payload_i,
  input  logic [nfp_pkg::HdrW-1:0]    hdr_bytes_i,
  output logic                        div_start_o,
  output logic [nfp_pkg::DivNumW-1:0] div_num_o,
  output logic [nfp_pkg::DivDenW-1:0] div_den_o,
  input  logic                        div_done_i,
  input  logic [nfp_pkg::DivNumW-1:0] div_quo_i,
  input  logic [nfp_pkg::DivDenW-1:0] div_rem_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output nfp_pkg::job_t               job_o,
  output logic [CntW-1:0]             job_cnt_o,
  output logic [CntW-1:0]             job_rem_o
);

  localparam int unsigned FieldW  = nfp_pkg::FieldW;
  localparam int unsigned MaxPayW = nfp_pkg::MaxPayW;
  localparam int unsigned NumW    = nfp_pkg::DivNumW;
  localparam int unsigned DenW    = nfp_pkg::DivDenW;

  nfp_pkg::front_state_e state_q, state_d;

  nfp_pkg::job_t       job_q;
  logic [FieldW-1:0]   data_q;
  logic [MaxPayW-1:0]  pf_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     rem_q;

  logic                accept;
  logic [FieldW-1:0]   size;
  logic [nfp_pkg::HdrW-1:0] hb;
  logic [FieldW-1:0]   hb_w;
  logic [MaxPayW-1:0]  hb1_p;
  logic                fits;
  logic                too_many;

  assign accept = in_valid_i && !in_stall_o;
  assign size   = in_data_i.nal_size & nfp_pkg::SizeMask;

  // Header length 0 acts as 1, 3 acts as 2
  always_comb begin
    unique case (hdr_bytes_i)
      2'd0:    hb = 2'd1;
      2'd3:    hb = 2'd2;
      default: hb = hdr_bytes_i;
    endcase
  end

  assign hb_w     = FieldW'(hb);
  assign hb1_p    = MaxPayW'(hb) + MaxPayW'(1);
  assign fits     = size <= FieldW'(max_payload_i);
  assign too_many = div_quo_i > NumW'(MaxFragments);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nfp_pkg::FIdle: begin
        if (accept) begin
          if (!in_data_i.header_valid || fits) begin
            state_d = nfp_pkg::FPush;
          end else begin
            state_d = nfp_pkg::FCntStart;
          end
        end
      end
      nfp_pkg::FCntStart: state_d = nfp_pkg::FCntWait;
      nfp_pkg::FCntWait: begin
        if (div_done_i) begin
          state_d = too_many ? nfp_pkg::FPush : nfp_pkg::FSplStart;
        end
      end
      nfp_pkg::FSplStart: state_d = nfp_pkg::FSplWait;
      nfp_pkg::FSplWait: begin
        if (div_done_i) begin
          state_d = nfp_pkg::FPush;
        end
      end
      nfp_pkg::FPush: begin
        if (job_ready_i) begin
          state_d = nfp_pkg::FIdle;
        end
      end
      default: state_d = nfp_pkg::FIdle;
    endcase
  end

  // Outputs per state; divider operands follow the phase
  always_comb begin
    in_stall_o  = 1'b1;
    div_start_o = 1'b0;
    job_valid_o = 1'b0;
    div_num_o   = {1'b0, data_q} + NumW'(pf_q) - NumW'(1);
    div_den_o   = pf_q;
    unique case (state_q)
      nfp_pkg::FIdle:     in_stall_o = 1'b0;
      nfp_pkg::FCntStart: div_start_o = 1'b1;
      nfp_pkg::FSplStart: begin
        div_start_o = 1'b1;
        div_num_o   = {1'b0, data_q};
        div_den_o   = DenW'(cnt_q);
      end
      nfp_pkg::FPush:     job_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfp_pkg::FIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Job fields, captured as each phase completes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.nal_type  <= in_data_i.nal_type;
      job_q.frame_end <= in_data_i.frame_end;
      job_q.hdr_bytes <= hb;
      if (!in_data_i.header_valid) begin
        job_q.kind   <= nfp_pkg::JobBad;
        job_q.amount <= '0;
      end else if (fits) begin
        job_q.kind   <= nfp_pkg::JobSingle;
        job_q.amount <= size;
      end else begin
        job_q.kind   <= nfp_pkg::JobFrag;
        job_q.amount <= '0;
      end
      data_q <= (size > hb_w) ? size - hb_w : '0;
      pf_q   <= (max_payload_i > hb1_p) ? max_payload_i - hb1_p : MaxPayW'(1);
    end else if (state_q == nfp_pkg::FCntWait && div_done_i) begin
      if (too_many) begin
        job_q.kind <= nfp_pkg::JobTooMany;
      end
      cnt_q <= (div_quo_i == '0) ? CntW'(1) : div_quo_i[CntW-1:0];
    end else if (state_q == nfp_pkg::FSplWait && div_done_i) begin
      job_q.amount <= div_quo_i[FieldW-1:0];
      rem_q        <= div_rem_i[CntW-1:0];
    end
  end

  assign job_o     = job_q;
  assign job_cnt_o = cnt_q;
  assign job_rem_o = rem_q;

endmodule

### rtl/core/nfp_queue.sv
// Short FIFO of classified jobs between front and back.
// Depends on nfp_pkg for its depth.
module nfp_queue #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [DataW-1:0] data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o
);

  localparam int unsigned Depth = nfp_pkg::QDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  fill_q;
  logic             do_push, do_pop;

  assign ready_o = fill_q != CntW'(Depth);
  assign valid_o = fill_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/core/nfp_back.sv
// Back end: walks one job and emits one descriptor per cycle while the output is
// not stalled, through an output register. Depends on nfp_pkg.
module nfp_back #(
  parameter int unsigned CntW = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_pop_o,
  input  nfp_pkg::job_t      job_i,
  input  logic [CntW-1:0]    job_cnt_i,
  input  logic [CntW-1:0]    job_rem_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nfp_pkg::out_item_t out_data_o
);

  localparam int unsigned FieldW = nfp_pkg::FieldW;

  nfp_pkg::back_state_e state_q, state_d;

  nfp_pkg::job_t      cur_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    rem_q;
  logic [CntW-1:0]    idx_q;
  logic [FieldW-1:0]  off_q;
  logic               out_valid_q;
  nfp_pkg::out_item_t out_q;

  nfp_pkg::out_item_t res;
  logic               load_en;
  logic               emit;
  logic               pop;
  logic               first;
  logic               last;
  logic [FieldW-1:0]  chunk;

  assign load_en = !out_valid_q || !out_stall_i;

  // Fragment position and size: the first rem fragments get one byte more
  assign first = idx_q == '0;
  assign last  = (idx_q + CntW'(1)) == cnt_q;
  assign chunk = cur_q.amount + FieldW'(idx_q < rem_q);

  // Descriptor for the current position
  always_comb begin
    res = '0;
    unique case (cur_q.kind)
      nfp_pkg::JobBad: begin
        res.status      = nfp_pkg::StBadHeader;
        res.last_result = 1'b1;
      end
      nfp_pkg::JobTooMany: begin
        res.status      = nfp_pkg::StTooMany;
        res.last_result = 1'b1;
      end
      nfp_pkg::JobSingle: begin
        res.status       = nfp_pkg::StPacket;
        res.copy_bytes   = cur_q.amount;
        res.payload_size = cur_q.amount;
        res.marker       = cur_q.frame_end;
        res.last_result  = 1'b1;
      end
      nfp_pkg::JobFrag: begin
        res.status       = nfp_pkg::StPacket;
        res.fragmented   = 1'b1;
        res.fu_header    = (first ? nfp_pkg::FuStart : '0)
                         | (last ? nfp_pkg::FuEnd : '0)
                         | (nfp_pkg::FuW'(cur_q.nal_type) & nfp_pkg::TypeMask);
        res.chunk_offset = off_q;
        res.copy_bytes   = chunk;
        res.payload_size = FieldW'(cur_q.hdr_bytes) + FieldW'(1) + chunk;
        res.marker       = last && cur_q.frame_end;
        res.last_result  = last;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nfp_pkg::BIdle: begin
        if (job_valid_i) begin
          state_d = nfp_pkg::BEmit;
        end
      end
      nfp_pkg::BEmit: begin
        if (emit && res.last_result && !job_valid_i) begin
          state_d = nfp_pkg::BIdle;
        end
      end
      default: state_d = nfp_pkg::BIdle;
    endcase
  end

  // Emit and pop strobes
  always_comb begin
    emit = 1'b0;
    pop  = 1'b0;
    unique case (state_q)
      nfp_pkg::BIdle: pop = job_valid_i;
      nfp_pkg::BEmit: begin
        emit = load_en;
        pop  = job_valid_i && load_en && res.last_result;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nfp_pkg::BIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_en) begin
        out_valid_q <= emit;
      end
    end
  end

  // Job walk and output register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= job_i;
      cnt_q <= job_cnt_i;
      rem_q <= job_rem_i;
      idx_q <= '0;
      off_q <= FieldW'(job_i.hdr_bytes);
    end else if (emit) begin
      idx_q <= idx_q + CntW'(1);
      off_q <= off_q + chunk;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign job_pop_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/nal_unit_fragment_planner_unit.sv
// Top level of the NAL unit fragment planner; uses nfp_pkg and the front, divider, queue, back.
// Invalid-header and single-packet units go straight to the job queue; too-many units are
// classified after one pass of the shared divider, fragmented units after two 21-step passes.
// The front takes a new unit only once it has queued the last one; the back emits one
// descriptor per cycle while the output is not stalled. Reset: rst_ni async low, clears
// control, loads max_payload 1200 and header length 1.
module nal_unit_fragment_planner_unit #(
  parameter int unsigned MAX_FRAGMENTS = nfp_pkg::MaxFragmentsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  nfp_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output nfp_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [nfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nfp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_FRAGMENTS + 1);
  localparam int unsigned QW   = $bits(nfp_pkg::job_t) + 2 * CntW;

  logic [nfp_pkg::MaxPayW-1:0] max_payload_q;
  logic [nfp_pkg::HdrW-1:0]    hdr_bytes_q;

  logic                        div_start;
  logic [nfp_pkg::DivNumW-1:0] div_num;
  logic [nfp_pkg::DivDenW-1:0] div_den;
  logic                        div_done;
  logic [nfp_pkg::DivNumW-1:0] div_quo;
  logic [nfp_pkg::DivDenW-1:0] div_rem;

  logic          fj_valid, fj_ready;
  nfp_pkg::job_t fj_job;
  logic [CntW-1:0] fj_cnt, fj_rem;

  logic          bj_valid, bj_pop;
  logic [QW-1:0] bj_data;
  nfp_pkg::job_t bj_job;
  logic [CntW-1:0] bj_cnt, bj_rem;

  // Configuration registers; the port never pushes back
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= nfp_pkg::MaxPayloadRst;
      hdr_bytes_q   <= nfp_pkg::HdrBytesRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == nfp_pkg::CfgMaxPayload) begin
        max_payload_q <= cfg_data_i[nfp_pkg::MaxPayW-1:0];
      end else if (cfg_index_i == nfp_pkg::CfgHdrBytes) begin
        hdr_bytes_q <= cfg_data_i[nfp_pkg::HdrW-1:0];
      end
    end
  end

  nfp_front #(
    .MaxFragments (MAX_FRAGMENTS),
    .CntW         (CntW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .max_payload_i (max_payload_q),
    .hdr_bytes_i   (hdr_bytes_q),
    .div_start_o   (div_start),
    .div_num_o     (div_num),
    .div_den_o     (div_den),
    .div_done_i    (div_done),
    .div_quo_i     (div_quo),
    .div_rem_i     (div_rem),
    .job_valid_o   (fj_valid),
    .job_ready_i   (fj_ready),
    .job_o         (fj_job),
    .job_cnt_o     (fj_cnt),
    .job_rem_o     (fj_rem)
  );

  nfp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  nfp_queue #(
    .DataW (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fj_valid),
    .ready_o (fj_ready),
    .data_i  ({fj_job, fj_cnt, fj_rem}),
    .valid_o (bj_valid),
    .pop_i   (bj_pop),
    .data_o  (bj_data)
  );

  assign {bj_job, bj_cnt, bj_rem} = bj_data;

  nfp_back #(
    .CntW (CntW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_pop_o   (bj_pop),
    .job_i       (bj_job),
    .job_cnt_i   (bj_cnt),
    .job_rem_i   (bj_rem),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/nfp_checker.sv
// Port-level checks on the fragment planner's result stream, bound to the
// top level. Depends on nfp_pkg.
module nfp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input nfp_pkg::out_item_t out_data_i
);

  // A stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // Error results end their unit
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != nfp_pkg::StPacket |-> out_data_i.last_result)
    else $error("error result not marked last");

  // A single packet carries the whole unit and ends it
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == nfp_pkg::StPacket && !out_data_i.fragmented
    |-> out_data_i.last_result && out_data_i.copy_bytes == out_data_i.payload_size)
    else $error("single packet inconsistent");

  // FU end bit matches the last fragment
  a_fu_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.fragmented |-> out_data_i.fu_header[6] == out_data_i.last_result)
    else $error("FU end bit disagrees with last result");

  // Marker only on the final packet of a unit
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.marker |-> out_data_i.last_result)
    else $error("marker on a non-final packet");

endmodule

bind nal_unit_fragment_planner_unit nfp_checker u_nfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

### sim/nfp_plan_checker.sv
// Checker for the NAL unit fragment planner: watches the input, output and
// register channels, plans the expected descriptors and compares them.
// Depends on nfp_pkg for the transaction structs, status codes and indexes.
module nfp_plan_checker #(
  parameter int unsigned MAX_FRAGMENTS = nfp_pkg::MaxFragmentsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  nfp_pkg::in_item_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  nfp_pkg::out_item_t           out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [nfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nfp_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import nfp_pkg::*;

  // Shadow copy of the two registers
  logic [MaxPayW-1:0] max_payload;
  logic [HdrW-1:0]    hdr_bytes;

  out_item_t   planned_q[$];
  int unsigned fails = 0;

  // Work out every descriptor one NAL unit gives and queue them in order
  task automatic plan_unit(input in_item_t u);
    out_item_t   d;
    int unsigned size, hb, data, per_frag, count, rem, off, chunk, left, i;
    d = '0;
    d.last_result = 1'b1;
    size = int'(u.nal_size & SizeMask);
    if (!u.header_valid) begin
      d.status = StBadHeader;
      planned_q.push_back(d);
    end else if (size <= max_payload) begin
      d.status       = StPacket;
      d.copy_bytes   = FieldW'(size);
      d.payload_size = FieldW'(size);
      d.marker       = u.frame_end;
      planned_q.push_back(d);
    end else begin
      // header length 0 behaves as 1, 3 as 2
      hb = (hdr_bytes == 2'd0) ? 1 : (hdr_bytes == 2'd3) ? 2 : hdr_bytes;
      data = (size > hb) ? size - hb : 0;
      per_frag = (max_payload > hb + 1) ? max_payload - hb - 1 : 1;
      count = (data + per_frag - 1) / per_frag;
      if (count == 0) count = 1;
      if (count > MAX_FRAGMENTS) begin
        d.status = StTooMany;
        planned_q.push_back(d);
      end else begin
        rem = data;
        off = hb;
        // spread the data evenly, larger chunks first
        for (i = 1; i <= count; i++) begin
          left  = count + 1 - i;
          chunk = (rem + left - 1) / left;
          if (chunk > rem) chunk = rem;
          d = '0;
          d.status       = StPacket;
          d.fragmented   = 1'b1;
          d.fu_header    = ((i == 1) ? FuStart : '0) | ((i == count) ? FuEnd : '0) |
                           (FuW'(u.nal_type) & TypeMask);
          d.chunk_offset = FieldW'(off);
          d.copy_bytes   = FieldW'(chunk);
          d.payload_size = FieldW'(hb + 1 + chunk);
          d.marker       = (i == count) ? u.frame_end : 1'b0;
          d.last_result  = (i == count);
          planned_q.push_back(d);
          rem -= chunk;
          off += chunk;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  // Transaction monitor: results first, then register writes, then new units
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp;
    if (!rst_ni) begin
      max_payload = MaxPayloadRst;
      hdr_bytes   = HdrBytesRst;
      planned_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (planned_q.size() == 0) begin
          $error("descriptor with none outstanding: status %0d, offset %0d, size %0d",
                 out_data_i.status, out_data_i.chunk_offset, out_data_i.copy_bytes);
          fails++;
        end else begin
          exp = planned_q.pop_front();
          check_field("status", exp.status, out_data_i.status);
          check_field("fragmented", exp.fragmented, out_data_i.fragmented);
          check_field("fu_header", exp.fu_header, out_data_i.fu_header);
          check_field("chunk_offset", exp.chunk_offset, out_data_i.chunk_offset);
          check_field("copy_bytes", exp.copy_bytes, out_data_i.copy_bytes);
          check_field("payload_size", exp.payload_size, out_data_i.payload_size);
          check_field("marker", exp.marker, out_data_i.marker);
          check_field("last_result", exp.last_result, out_data_i.last_result);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgMaxPayload) max_payload = cfg_data_i;
        else if (cfg_index_i == CfgHdrBytes) hdr_bytes = cfg_data_i[HdrW-1:0];
      end
      if (in_valid_i && !in_stall_i) plan_unit(in_data_i);
    end
    pending_o    <= planned_q.size();
    fail_count_o <= fails;
  end

endmodule

### sim/nal_unit_fragment_planner_unit_tb.sv
// Testbench top for nal_unit_fragment_planner_unit: clock, reset, stimulus,
// register phases, output back-pressure, watchdog and verdict.
// Depends on nfp_pkg, the planner RTL and nfp_plan_checker.
module nal_unit_fragment_planner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfp_pkg::*;

  localparam int unsigned MaxFrags     = MaxFragmentsDef;
  localparam int unsigned SizeMax      = (1 << FieldW) - 1;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned UnitsPerPhase = 46;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned WatchLimit   = 3000;
  localparam int unsigned TailCycles   = 100;
  localparam int unsigned IdlePct      = 31;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 4'hF;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  logic        calm;      // no random idling on either side
  logic        hold_req;  // asks the receiver for one long hold-off

  // Register settings as the stimulus shapes them (header length clamped)
  int unsigned cur_max_pay;
  int unsigned cur_hb;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  nal_unit_fragment_planner_unit #(
    .MAX_FRAGMENTS(MaxFrags)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  nfp_plan_checker #(
    .MAX_FRAGMENTS(MaxFrags)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic in_item_t mk_unit(input int unsigned size, input int unsigned nal_type,
                                       input bit hdr_ok, input bit fend);
    in_item_t u;
    u.nal_size     = FieldW'(size);
    u.nal_type     = TypeW'(nal_type);
    u.header_valid = hdr_ok;
    u.frame_end    = fend;
    return u;
  endfunction

  // Random unit sized around the current fragment limit: mostly units that
  // split into a handful of fragments, some single, some over the limit
  function automatic in_item_t rand_unit();
    int unsigned per_frag, pick, frags, size;
    per_frag = (cur_max_pay > cur_hb + 1) ? cur_max_pay - cur_hb - 1 : 1;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      size = $urandom_range(0, cur_max_pay);
    end else if (pick < 75) begin
      frags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxFrags) : $urandom_range(1, 6);
      size = cur_hb + per_frag * (frags - 1) + $urandom_range(1, per_frag);
    end else if (pick < 85) begin
      size = cur_hb + per_frag * MaxFrags + $urandom_range(1, per_frag);
    end else begin
      size = $urandom_range(0, SizeMax);
    end
    if (size > SizeMax) size = $urandom_range(0, SizeMax);
    return mk_unit(size, $urandom_range(0, 63), $urandom_range(0, 9) != 0,
                   $urandom_range(0, 1));
  endfunction

  // Offer one unit; valid stays high afterwards unless the next call idles
  task automatic send_unit(input in_item_t u);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= u;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait until every planned descriptor has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limits(input int unsigned max_pay, input int unsigned hdr);
    drain();
    write_reg(CfgMaxPayload, max_pay);
    write_reg(CfgHdrBytes, hdr);
    cur_max_pay = max_pay;
    cur_hb = (hdr == 0) ? 1 : (hdr == 3) ? 2 : hdr;
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WatchLimit) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned pay_tab [PhaseCount];
    int unsigned hdr_tab [PhaseCount];
    int unsigned ph, n;
    pay_tab = '{1200, 4, 65535, 100, 1500, 9, 700, 4};
    hdr_tab = '{1, 1, 2, 0, 3, 2, 1, 2};
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    calm        <= 1'b0;
    hold_req    <= 1'b0;
    cur_max_pay = MaxPayloadRst;
    cur_hb      = HdrBytesRst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: limit edges, even split, fragment count edges
    send_unit(mk_unit(0, 0, 1'b1, 1'b1));
    send_unit(mk_unit(1200, 63, 1'b1, 1'b1));
    send_unit(mk_unit(1201, 42, 1'b1, 1'b1));
    send_unit(mk_unit(2399, 21, 1'b1, 1'b0));
    send_unit(mk_unit(76673, 5, 1'b1, 1'b1));
    send_unit(mk_unit(76674, 5, 1'b1, 1'b1));
    send_unit(mk_unit(SizeMax, 63, 1'b1, 1'b1));
    send_unit(mk_unit(SizeMax, 63, 1'b0, 1'b1));
    send_unit(mk_unit(5000, 0, 1'b0, 1'b0));

    // Limit too small for a data byte; unit no longer than its header
    set_limits(1, 2);
    send_unit(mk_unit(1, 7, 1'b1, 1'b1));
    send_unit(mk_unit(2, 7, 1'b1, 1'b1));
    send_unit(mk_unit(66, 9, 1'b1, 1'b1));
    send_unit(mk_unit(67, 9, 1'b1, 1'b1));

    // Header length 0 behaves as 1, zero payload limit
    set_limits(0, 0);
    send_unit(mk_unit(0, 1, 1'b1, 1'b1));
    send_unit(mk_unit(1, 2, 1'b1, 1'b1));
    send_unit(mk_unit(65, 3, 1'b1, 1'b0));

    // Header length 3 behaves as 2, widest payload limit
    set_limits(65535, 3);
    send_unit(mk_unit(65535, 32, 1'b1, 1'b1));
    send_unit(mk_unit(65536, 32, 1'b1, 1'b1));
    send_unit(mk_unit(SizeMax, 63, 1'b1, 1'b1));
    drain();
    write_reg(CfgSpareIdx, 16'hFFFF);

    // Random phases over a spread of settings
    for (ph = 0; ph < PhaseCount; ph++) begin
      set_limits(pay_tab[ph], hdr_tab[ph]);
      calm <= (ph == 2);
      if (ph == 4) hold_req <= 1'b1;
      for (n = 0; n < UnitsPerPhase; n++) send_unit(rand_unit());
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### nal_unit_fragment_planner_unit.f
rtl/core/nfp_pkg.sv
rtl/core/nfp_div.sv
rtl/core/nfp_front.sv
rtl/core/nfp_queue.sv
rtl/core/nfp_back.sv
rtl/core/nal_unit_fragment_planner_unit.sv
rtl/core/nfp_checker.sv
sim/nfp_plan_checker.sv
sim/nal_unit_fragment_planner_unit_tb.sv
